FILE: rtl/core/cmmd_pkg.sv
package cmmd_pkg;

   // Region codes reported with each result
   localparam logic [2:0] REGION_NONE    = 3'd0;
   localparam logic [2:0] REGION_RAM     = 3'd1;
   localparam logic [2:0] REGION_PAR     = 3'd2;
   localparam logic [2:0] REGION_SCRATCH = 3'd3;
   localparam logic [2:0] REGION_IO      = 3'd4;
   localparam logic [2:0] REGION_CACHE   = 3'd5;

   // Access size codes
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   // Address map constants
   localparam logic [15:0] SEG_SCRATCH_IO = 16'h1f80;
   localparam logic [15:0] SEG_PAR        = 16'h1f00;
   localparam logic [15:0] SEG_ROM_LO     = 16'hbfc0;
   localparam logic [15:0] SEG_ROM_HI     = 16'hbfc7;
   localparam logic [15:0] SEG_KUSEG_END  = 16'h0080;
   localparam logic [15:0] SEG_KSEG0      = 16'h8000;
   localparam logic [15:0] SEG_KSEG0_END  = 16'h8080;
   localparam logic [15:0] SEG_KSEG1      = 16'ha000;
   localparam logic [15:0] SEG_KSEG1_END  = 16'ha080;
   localparam logic [31:0] IO_BOUNDARY    = 32'h1f80_1000;
   localparam logic [31:0] CACHE_CTRL     = 32'hfffe_0130;
   localparam logic [31:0] CODE_ISOLATE_A = 32'h0000_0800;
   localparam logic [31:0] CODE_ISOLATE_B = 32'h0000_0804;
   localparam logic [31:0] CODE_RESTORE   = 32'h0001_e988;

   typedef enum logic [2:0] {
      TGT_NONE,
      TGT_RAM,
      TGT_PAR,
      TGT_SCRATCH,
      TGT_ROM
   } tgt_type;

   typedef enum logic [1:0] {
      CACHE_OP_NONE,
      CACHE_OP_ISOLATE,
      CACHE_OP_RESTORE
   } cache_op_type;

   typedef struct packed {
      logic        command;
      logic [1:0]  access_size;
      logic [31:0] address;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [2:0]  region;
      logic        ram_isolated;
   } rsp_type;

   // Decoded access, handed from the decoder to the access control
   typedef struct packed {
      tgt_type      target;
      logic [2:0]   region;
      logic         is_write;
      logic [1:0]   size;
      logic [31:0]  addr_al;
      cache_op_type cache_op;
   } dec_type;

endpackage

FILE: rtl/core/console_memory_map_decoder.sv
// Channel   Ports                                  Direction  Word
// request   req_valid, req_ready, req_payload      in         req_type
// response  rsp_valid, rsp_ready, rsp_payload      out        rsp_type
//
// An access is accepted in ST_IDLE, which issues the memory read; in ST_ACCESS the
// block merges the word, writes it back and loads the response register.
// After reset the main RAM and the parallel store are swept to zero, one word
// a cycle, through every index below the larger of RAM_BYTES/4 and PARALLEL_BYTES/4;
// req_ready stays low until the sweep is done. A held response does not
// block the next accept, but that access waits in its merge cycle until the
// response is taken.
module console_memory_map_decoder
   import cmmd_pkg::*;
#(
   parameter int unsigned RAM_BYTES      = 2097152,
   parameter int unsigned PARALLEL_BYTES = 65536,
   parameter int unsigned ROM_BYTES      = 524288,
   parameter int unsigned SCRATCH_BYTES  = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int unsigned RAM_DEPTH = RAM_BYTES / 4;
   localparam int unsigned PAR_DEPTH = PARALLEL_BYTES / 4;
   localparam int unsigned ROM_DEPTH = ROM_BYTES / 4;
   localparam int unsigned SCR_DEPTH = SCRATCH_BYTES / 4;
   localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);
   localparam int unsigned PAR_AW    = $clog2(PAR_DEPTH);
   localparam int unsigned ROM_AW    = $clog2(ROM_DEPTH);
   localparam int unsigned SCR_AW    = $clog2(SCR_DEPTH);
   localparam int unsigned CLR_DEPTH = (RAM_DEPTH > PAR_DEPTH) ? RAM_DEPTH : PAR_DEPTH;
   localparam int unsigned CLR_AW    = $clog2(CLR_DEPTH);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS
   } state_type;

   state_type      state_ff;
   logic [CLR_AW:0] clr_idx_ff;
   dec_type        dec_ff;
   logic [31:0]    wdata_ff;
   logic           iso_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   dec_type        dec_in;
   logic           accept;
   logic           commit;
   logic           clearing;
   logic           iso_in;

   logic [31:0]    ram_rd, par_rd, scr_rd, rom_rd;
   logic [31:0]    old_word;
   logic [31:0]    lane_mask;
   logic [4:0]     lane_shift;
   logic [31:0]    shifted_mask;
   logic [31:0]    new_word;
   logic [31:0]    rd_value;

   logic                ram_wr_en, par_wr_en;
   logic [RAM_AW-1:0]   ram_wr_addr;
   logic [PAR_AW-1:0]   par_wr_addr;
   logic [31:0]         clr_wr_data;

   cmmd_decode u_decode (
      .req      (req_payload),
      .isolated (iso_ff),
      .dec      (dec_in)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == ST_ACCESS) && (!rsp_valid_ff || rsp_ready);
   assign clearing  = (state_ff == ST_CLEAR);

   // Pick the word read for the held access
   always_comb begin
      case (dec_ff.target)
         TGT_RAM:     old_word = ram_rd;
         TGT_PAR:     old_word = par_rd;
         TGT_SCRATCH: old_word = scr_rd;
         TGT_ROM:     old_word = rom_rd;
         default:     old_word = 32'd0;
      endcase
   end

   // Merge the write lanes and extract the read lanes
   always_comb begin
      case (dec_ff.size)
         SIZE_BYTE: lane_mask = 32'h0000_00ff;
         SIZE_HALF: lane_mask = 32'h0000_ffff;
         default:   lane_mask = 32'hffff_ffff;
      endcase
   end

   assign lane_shift   = {dec_ff.addr_al[1:0], 3'b000};
   assign shifted_mask = lane_mask << lane_shift;
   assign new_word     = (old_word & ~shifted_mask) | ((wdata_ff & lane_mask) << lane_shift);
   assign rd_value     = (old_word >> lane_shift) & lane_mask;

   // Advance the isolation mode on a cache control word write
   always_comb begin
      case (dec_ff.cache_op)
         CACHE_OP_ISOLATE: iso_in = 1'b1;
         CACHE_OP_RESTORE: iso_in = 1'b0;
         default:          iso_in = iso_ff;
      endcase
   end

   // Share the RAM and parallel write ports with the zeroing sweep
   assign clr_wr_data = 32'd0;
   assign ram_wr_en   = clearing ||
                        (commit && dec_ff.is_write && dec_ff.target == TGT_RAM);
   assign par_wr_en   = clearing ||
                        (commit && dec_ff.is_write && dec_ff.target == TGT_PAR);
   assign ram_wr_addr = clearing ? clr_idx_ff[RAM_AW-1:0] : dec_ff.addr_al[RAM_AW+1:2];
   assign par_wr_addr = clearing ? clr_idx_ff[PAR_AW-1:0] : dec_ff.addr_al[PAR_AW+1:2];

   cmmd_store #(.DEPTH(RAM_DEPTH)) u_ram (
      .clock   (clock),
      .rd_en   (accept && dec_in.target == TGT_RAM),
      .rd_addr (dec_in.addr_al[RAM_AW+1:2]),
      .rd_data (ram_rd),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (clearing ? clr_wr_data : new_word)
   );

   cmmd_store #(.DEPTH(PAR_DEPTH)) u_par (
      .clock   (clock),
      .rd_en   (accept && dec_in.target == TGT_PAR),
      .rd_addr (dec_in.addr_al[PAR_AW+1:2]),
      .rd_data (par_rd),
      .wr_en   (par_wr_en),
      .wr_addr (par_wr_addr),
      .wr_data (clearing ? clr_wr_data : new_word)
   );

   cmmd_store #(.DEPTH(SCR_DEPTH)) u_scratch (
      .clock   (clock),
      .rd_en   (accept && dec_in.target == TGT_SCRATCH),
      .rd_addr (dec_in.addr_al[SCR_AW+1:2]),
      .rd_data (scr_rd),
      .wr_en   (commit && dec_ff.is_write && dec_ff.target == TGT_SCRATCH),
      .wr_addr (dec_ff.addr_al[SCR_AW+1:2]),
      .wr_data (new_word)
   );

   cmmd_store #(.DEPTH(ROM_DEPTH)) u_rom (
      .clock   (clock),
      .rd_en   (accept && dec_in.target == TGT_ROM),
      .rd_addr (dec_in.addr_al[ROM_AW+1:2]),
      .rd_data (rom_rd),
      .wr_en   (commit && dec_ff.is_write && dec_ff.target == TGT_ROM),
      .wr_addr (dec_ff.addr_al[ROM_AW+1:2]),
      .wr_data (new_word)
   );

   // Hold the accepted access for its merge cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         dec_ff   <= dec_in;
         wdata_ff <= req_payload.write_data;
      end
   end

   // Sequence the sweep, the accesses and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         iso_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !commit) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + 1'b1;
               if (clr_idx_ff == (CLR_AW + 1)'(CLR_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_ACCESS;
               end
            end
            ST_ACCESS: begin
               if (commit) begin
                  iso_ff                <= iso_in;
                  rsp_valid_ff          <= 1'b1;
                  rsp_ff.read_data      <= dec_ff.is_write ? 32'd0 : rd_value;
                  rsp_ff.region         <= dec_ff.region;
                  rsp_ff.ram_isolated   <= iso_in;
                  state_ff              <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/core/cmmd_decode.sv
module cmmd_decode
   import cmmd_pkg::*;
(
   input  req_type req,
   input  logic    isolated,
   output dec_type dec
);

   logic [15:0] seg;
   logic [1:0]  size_n;
   logic        ram_seg;

   assign seg = req.address[31:16];

   // Treat size three as a word
   assign size_n = (req.access_size > SIZE_WORD) ? SIZE_WORD : req.access_size;

   assign ram_seg = (seg < SEG_KUSEG_END) ||
                    (seg >= SEG_KSEG0 && seg < SEG_KSEG0_END) ||
                    (seg >= SEG_KSEG1 && seg < SEG_KSEG1_END);

   always_comb begin
      dec.target   = TGT_NONE;
      dec.region   = REGION_NONE;
      dec.is_write = req.command;
      dec.size     = size_n;
      dec.cache_op = CACHE_OP_NONE;

      // Drop the address bits below the access size
      dec.addr_al = req.address;
      case (size_n)
         SIZE_BYTE: dec.addr_al = req.address;
         SIZE_HALF: dec.addr_al = {req.address[31:1], 1'b0};
         default:   dec.addr_al = {req.address[31:2], 2'b00};
      endcase

      if (seg == SEG_SCRATCH_IO) begin
         if (req.address < IO_BOUNDARY) begin
            dec.target = TGT_SCRATCH;
            dec.region = REGION_SCRATCH;
         end else begin
            dec.region = REGION_IO;
         end
      end else if (seg == SEG_PAR) begin
         dec.target = TGT_PAR;
         dec.region = REGION_PAR;
      end else if (seg >= SEG_ROM_LO && seg <= SEG_ROM_HI) begin
         // ROM has no region code of its own
         dec.target = TGT_ROM;
      end else if (ram_seg && !isolated) begin
         dec.target = TGT_RAM;
         dec.region = REGION_RAM;
      end else if ({req.address[31:2], 2'b00} == CACHE_CTRL) begin
         dec.region = REGION_CACHE;
         if (req.command && size_n == SIZE_WORD) begin
            if (req.write_data == CODE_ISOLATE_A || req.write_data == CODE_ISOLATE_B) begin
               dec.cache_op = CACHE_OP_ISOLATE;
            end else if (req.write_data == CODE_RESTORE) begin
               dec.cache_op = CACHE_OP_RESTORE;
            end
         end
      end
   end

endmodule

FILE: rtl/core/cmmd_store.sv
module cmmd_store #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [31:0]              rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [31:0]              wr_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   // Write one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one word, held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import cmmd_pkg::*;

   localparam logic       CMD_READ      = 1'b0;
   localparam logic       CMD_WRITE     = 1'b1;
   // Size code three decodes as a word access
   localparam logic [1:0] SIZE_ALT_WORD = 2'd3;

   localparam int unsigned RAM_SPAN     = 2097152;
   localparam int unsigned PAR_SPAN     = 65536;
   localparam int unsigned SCRATCH_SPAN = 4096;
   localparam int unsigned ROM_SPAN     = 524288;

   localparam int RANDOM_ITEMS = 1800;
   localparam int QUIET_ITEMS  = 200;
   localparam int CYCLE_LIMIT  = 4000000;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   console_memory_map_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predicted memory contents, keyed by {target, word index}
   logic [31:0] store_words   [int unsigned];
   logic [3:0]  lanes_written [int unsigned];
   logic        ram_unmapped = 1'b0;
   rsp_type     replies_due [$];
   logic [31:0] recent_addrs [$];

   int fail_count    = 0;
   int cycle_count   = 0;
   int read_count    = 0;
   int write_count   = 0;
   int isolate_count = 0;
   int region_hits [8];

   int  idle_pct   = 0;
   int  stall_pct  = 0;
   bit  quiet_tail = 1'b0;
   int  ready_burst = 0;

   // Directed words; expected reply typed in where marked
   typedef struct packed {
      logic        cmd;
      logic [1:0]  sz;
      logic [31:0] addr;
      logic [31:0] data;
      logic        typed_in;
      logic [31:0] rd;
      logic [2:0]  rgn;
      logic        iso;
   } probe_row;

   localparam int PROBES = 26;

   probe_row probe_table [PROBES] = '{
      // RAM after reset, window extremes
      '{CMD_READ,  SIZE_WORD, 32'h0000_0000, 32'h0, 1'b1, 32'h0, REGION_RAM, 1'b0},
      '{CMD_READ,  SIZE_WORD, 32'h801f_fffc, 32'h0, 1'b1, 32'h0, REGION_RAM, 1'b0},
      '{CMD_READ,  SIZE_BYTE, 32'ha07f_ffff, 32'h0, 1'b1, 32'h0, REGION_RAM, 1'b0},
      '{CMD_WRITE, SIZE_WORD, 32'h0000_0000, 32'hdead_beef, 1'b1, 32'h0, REGION_RAM, 1'b0},
      // mirrors, unaligned half, size three
      '{CMD_READ,  SIZE_BYTE, 32'h8060_0001, 32'h0, 1'b0, 32'h0, REGION_NONE, 1'b0},
      '{CMD_READ,  SIZE_HALF, 32'ha020_0003, 32'h0, 1'b0, 32'h0, REGION_NONE, 1'b0},
      '{CMD_READ,  SIZE_ALT_WORD, 32'h0000_0001, 32'h0, 1'b0, 32'h0, REGION_NONE, 1'b0},
      '{CMD_WRITE, SIZE_BYTE, 32'h007f_ffff, 32'h0000_00a5, 1'b1, 32'h0, REGION_RAM, 1'b0},
      // parallel store
      '{CMD_READ,  SIZE_WORD, 32'h1f00_0000, 32'h0, 1'b1, 32'h0, REGION_PAR, 1'b0},
      '{CMD_WRITE, SIZE_HALF, 32'h1f00_fffe, 32'hffff_ffff, 1'b1, 32'h0, REGION_PAR, 1'b0},
      '{CMD_READ,  SIZE_WORD, 32'h1f00_fffc, 32'h0, 1'b0, 32'h0, REGION_NONE, 1'b0},
      // scratchpad and I/O either side of the boundary
      '{CMD_WRITE, SIZE_WORD, 32'h1f80_0000, 32'h1234_5678, 1'b1, 32'h0, REGION_SCRATCH, 1'b0},
      '{CMD_WRITE, SIZE_WORD, 32'h1f80_0ffc, 32'hffff_ffff, 1'b1, 32'h0, REGION_SCRATCH, 1'b0},
      '{CMD_READ,  SIZE_BYTE, 32'h1f80_0ffe, 32'h0, 1'b0, 32'h0, REGION_NONE, 1'b0},
      '{CMD_READ,  SIZE_WORD, 32'h1f80_1000, 32'h0, 1'b1, 32'h0, REGION_IO, 1'b0},
      '{CMD_WRITE, SIZE_WORD, 32'h1f80_ffff, 32'hffff_ffff, 1'b1, 32'h0, REGION_IO, 1'b0},
      // ROM reports no region but keeps its data
      '{CMD_WRITE, SIZE_WORD, 32'hbfc0_0000, 32'h0f0f_f0f0, 1'b1, 32'h0, REGION_NONE, 1'b0},
      '{CMD_WRITE, SIZE_WORD, 32'hbfc7_fffc, 32'ha5a5_5a5a, 1'b1, 32'h0, REGION_NONE, 1'b0},
      '{CMD_READ,  SIZE_HALF, 32'hbfc7_ffff, 32'h0, 1'b0, 32'h0, REGION_NONE, 1'b0},
      '{CMD_READ,  SIZE_WORD, 32'hbfc8_0000, 32'h0, 1'b1, 32'h0, REGION_NONE, 1'b0},
      '{CMD_READ,  SIZE_WORD, 32'h0080_0000, 32'h0, 1'b1, 32'h0, REGION_NONE, 1'b0},
      // cache control: isolate, wrong size, repeated mode, unaligned restore
      '{CMD_WRITE, SIZE_WORD, 32'hfffe_0130, CODE_ISOLATE_A, 1'b1, 32'h0, REGION_CACHE, 1'b1},
      '{CMD_READ,  SIZE_WORD, 32'h8000_0000, 32'h0, 1'b1, 32'h0, REGION_NONE, 1'b1},
      '{CMD_WRITE, SIZE_BYTE, 32'hfffe_0133, CODE_RESTORE, 1'b1, 32'h0, REGION_CACHE, 1'b1},
      '{CMD_WRITE, SIZE_WORD, 32'hfffe_0130, CODE_ISOLATE_B, 1'b1, 32'h0, REGION_CACHE, 1'b1},
      '{CMD_WRITE, SIZE_WORD, 32'hfffe_0131, CODE_RESTORE, 1'b1, 32'h0, REGION_CACHE, 1'b0}
   };

   // Decode an address against the map
   function automatic void classify(input logic [31:0] addr, input logic iso,
                                    output tgt_type tgt, output logic [2:0] rgn);
      logic [15:0] seg;
      seg = addr[31:16];
      tgt = TGT_NONE;
      rgn = REGION_NONE;
      if (seg == SEG_SCRATCH_IO) begin
         if (addr < IO_BOUNDARY) begin
            tgt = TGT_SCRATCH;
            rgn = REGION_SCRATCH;
         end else begin
            rgn = REGION_IO;
         end
      end else if (seg == SEG_PAR) begin
         tgt = TGT_PAR;
         rgn = REGION_PAR;
      end else if (seg >= SEG_ROM_LO && seg <= SEG_ROM_HI) begin
         tgt = TGT_ROM;
      end else if ((seg < SEG_KUSEG_END || (seg >= SEG_KSEG0 && seg < SEG_KSEG0_END) ||
                    (seg >= SEG_KSEG1 && seg < SEG_KSEG1_END)) && !iso) begin
         tgt = TGT_RAM;
         rgn = REGION_RAM;
      end else if ({addr[31:2], 2'b00} == CACHE_CTRL) begin
         rgn = REGION_CACHE;
      end
   endfunction

   // Find the word, byte lanes and shift that an access touches
   function automatic void locate(input tgt_type tgt, input logic [31:0] addr,
                                  input logic [1:0] sz, output int unsigned key,
                                  output logic [3:0] lanes, output logic [4:0] shift,
                                  output logic [31:0] mask);
      logic [31:0] span;
      logic [31:0] off;
      case (tgt)
         TGT_RAM:     span = RAM_SPAN;
         TGT_PAR:     span = PAR_SPAN;
         TGT_SCRATCH: span = SCRATCH_SPAN;
         default:     span = ROM_SPAN;
      endcase
      off = addr & (span - 1);
      case (sz)
         SIZE_BYTE: begin
            lanes = 4'b0001;
            mask  = 32'h0000_00ff;
         end
         SIZE_HALF: begin
            off[0] = 1'b0;
            lanes  = 4'b0011;
            mask   = 32'h0000_ffff;
         end
         default: begin
            off[1:0] = 2'b00;
            lanes    = 4'b1111;
            mask     = 32'hffff_ffff;
         end
      endcase
      lanes = lanes << off[1:0];
      shift = {off[1:0], 3'b000};
      key   = {10'd0, tgt, off[20:2]};
   endfunction

   function automatic logic [31:0] touch_store(tgt_type tgt, logic [31:0] addr, logic wr,
                                               logic [1:0] sz, logic [31:0] data);
      int unsigned key;
      logic [3:0]  lanes;
      logic [4:0]  shift;
      logic [31:0] mask;
      logic [31:0] word;
      locate(tgt, addr, sz, key, lanes, shift, mask);
      word = store_words.exists(key) ? store_words[key] : 32'h0;
      if (wr) begin
         store_words[key]   = (word & ~(mask << shift)) | ((data & mask) << shift);
         lanes_written[key] = (lanes_written.exists(key) ? lanes_written[key] : 4'b0) | lanes;
         return 32'h0;
      end
      return (word >> shift) & mask;
   endfunction

   // Scratch and ROM bytes may only be read once written
   function automatic bit lanes_defined(tgt_type tgt, logic [31:0] addr, logic [1:0] sz);
      int unsigned key;
      logic [3:0]  lanes;
      logic [4:0]  shift;
      logic [31:0] mask;
      if (tgt != TGT_SCRATCH && tgt != TGT_ROM)
         return 1'b1;
      locate(tgt, addr, sz, key, lanes, shift, mask);
      return lanes_written.exists(key) && ((lanes_written[key] & lanes) == lanes);
   endfunction

   // Predict the reply to one bus word and advance the memory image
   function automatic rsp_type decode_access(req_type w);
      rsp_type     reply;
      tgt_type     tgt;
      logic [2:0]  rgn;
      logic [1:0]  sz;
      logic [31:0] rd;
      logic        wr;
      wr = (w.command == CMD_WRITE);
      sz = (w.access_size == SIZE_ALT_WORD) ? SIZE_WORD : w.access_size;
      classify(w.address, ram_unmapped, tgt, rgn);
      rd = 32'h0;
      if (tgt != TGT_NONE)
         rd = touch_store(tgt, w.address, wr, sz, w.write_data);
      if (rgn == REGION_CACHE && wr && sz == SIZE_WORD) begin
         if (w.write_data == CODE_ISOLATE_A || w.write_data == CODE_ISOLATE_B) begin
            if (!ram_unmapped)
               isolate_count++;
            ram_unmapped = 1'b1;
         end else if (w.write_data == CODE_RESTORE) begin
            ram_unmapped = 1'b0;
         end
      end
      reply.read_data    = wr ? 32'h0 : rd;
      reply.region       = rgn;
      reply.ram_isolated = ram_unmapped;
      return reply;
   endfunction

   // Draw one random bus word, mostly aimed at mapped stores
   function automatic req_type draw_access();
      req_type     w;
      tgt_type     tgt;
      logic [2:0]  rgn;
      logic [1:0]  sz;
      int unsigned pick;
      pick          = $urandom_range(0, 99);
      w.command     = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
      w.access_size = 2'($urandom_range(0, 3));
      w.write_data  = $urandom;
      if (pick < 40) begin
         case ($urandom_range(0, 2))
            0:       w.address = 32'h0000_0000;
            1:       w.address = 32'h8000_0000;
            default: w.address = 32'ha000_0000;
         endcase
         if ($urandom_range(0, 1))
            w.address = w.address | ($urandom & 32'h007f_ffff);
         else
            w.address = w.address | ($urandom_range(0, 3) << 21) |
                        ($urandom_range(0, 1) ? 32'h001f_fc00 : 32'h0) |
                        $urandom_range(0, 1023);
      end else if (pick < 52) begin
         w.address = 32'h1f00_0000 |
                     ($urandom_range(0, 1) ? ($urandom & 32'hffff) : $urandom_range(0, 511));
      end else if (pick < 64) begin
         w.address = 32'h1f80_0000 |
                     ($urandom_range(0, 1) ? ($urandom & 32'hfff) : $urandom_range(0, 63));
      end else if (pick < 70) begin
         w.address = 32'h1f80_1000 + $urandom_range(0, 32'hefff);
      end else if (pick < 80) begin
         w.address = 32'hbfc0_0000 |
                     ($urandom_range(0, 1) ? ($urandom & 32'h7ffff) : $urandom_range(0, 255));
      end else if (pick < 84) begin
         w.address = CACHE_CTRL | $urandom_range(0, 3);
         w.command = ($urandom_range(0, 7) != 0) ? CMD_WRITE : CMD_READ;
         if ($urandom_range(0, 3) != 0)
            w.access_size = SIZE_WORD;
         case ($urandom_range(0, 7))
            0:       w.write_data = CODE_ISOLATE_A;
            1:       w.write_data = CODE_ISOLATE_B;
            6:       w.write_data = CODE_ISOLATE_A ^ (32'h1 << $urandom_range(0, 31));
            7:       w.write_data = $urandom;
            default: w.write_data = CODE_RESTORE;
         endcase
      end else if (pick < 92 && recent_addrs.size() != 0) begin
         // revisit a recently written address with a fresh size and offset
         w.address      = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
         w.address[1:0] = 2'($urandom_range(0, 3));
         w.command      = ($urandom_range(0, 3) != 0) ? CMD_READ : CMD_WRITE;
      end else begin
         w.address = $urandom;
      end
      sz = (w.access_size == SIZE_ALT_WORD) ? SIZE_WORD : w.access_size;
      classify(w.address, ram_unmapped, tgt, rgn);
      if (w.command == CMD_READ && !lanes_defined(tgt, w.address, sz))
         w.command = CMD_WRITE;
      if (w.command == CMD_WRITE && tgt != TGT_NONE) begin
         recent_addrs.push_back(w.address);
         if (recent_addrs.size() > 16)
            void'(recent_addrs.pop_front());
      end
      return w;
   endfunction

   // Offer one word, hold it until taken, then record its reply
   task automatic issue_access(input req_type w, input logic typed_in, input rsp_type typed_rsp);
      rsp_type predicted;
      req_valid   <= 1'b1;
      req_payload <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predicted = decode_access(w);
      replies_due.push_back(typed_in ? typed_rsp : predicted);
      if (w.command == CMD_WRITE)
         write_count++;
      else
         read_count++;
   endtask

   task automatic idle_maybe();
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16))
            @(posedge clock);
      end
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (replies_due.size() != 0);
   endtask

   // Stimulus: directed table, then random words in chunks of varying idle rates
   initial begin
      probe_row row;
      repeat (3)
         @(posedge clock);
      reset     <= 1'b0;
      idle_pct  = 20;
      stall_pct = 20;
      foreach (probe_table[i]) begin
         row = probe_table[i];
         issue_access(req_type'({row.cmd, row.sz, row.addr, row.data}), row.typed_in,
                      rsp_type'({row.rd, row.rgn, row.iso}));
         idle_maybe();
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
            quiet_tail = 1'b1;
            idle_pct   = 0;
            stall_pct  = 0;
         end else if (n % 150 == 0 && !quiet_tail) begin
            case ($urandom_range(0, 3))
               0:       idle_pct = 0;
               1:       idle_pct = 10;
               2:       idle_pct = 30;
               default: idle_pct = 60;
            endcase
            case ($urandom_range(0, 3))
               0:       stall_pct = 0;
               1:       stall_pct = 10;
               2:       stall_pct = 30;
               default: stall_pct = 60;
            endcase
         end
         if (n == RANDOM_ITEMS / 2)
            drain_replies();
         issue_access(draw_access(), 1'b0, '0);
         idle_maybe();
      end
      drain_replies();
      repeat (4)
         @(posedge clock);
      $display("%0d bus words accepted: %0d reads, %0d writes; RAM isolated %0d times",
               read_count + write_count, read_count, write_count, isolate_count);
      $display("replies: unmapped/ROM %0d, RAM %0d, parallel %0d, scratch %0d, I/O %0d, cache %0d",
               region_hits[REGION_NONE], region_hits[REGION_RAM], region_hits[REGION_PAR],
               region_hits[REGION_SCRATCH], region_hits[REGION_IO], region_hits[REGION_CACHE]);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Stall the reply channel in random bursts; none in the quiet tail
   always @(posedge clock) begin
      if (quiet_tail || stall_pct == 0) begin
         rsp_ready   <= 1'b1;
         ready_burst <= 0;
      end else if (ready_burst == 0) begin
         rsp_ready   <= ($urandom_range(0, 99) >= stall_pct);
         ready_burst <= $urandom_range(1, 16);
      end else begin
         ready_burst <= ready_burst - 1;
      end
   end

   // Compare each taken reply word with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (replies_due.size() == 0) begin
            $error("reply with nothing outstanding: %h", rsp_payload);
            fail_count++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_payload.read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, rsp_payload.read_data);
               fail_count++;
            end
            if (rsp_payload.region !== want.region) begin
               $error("region: expected %0d, got %0d", want.region, rsp_payload.region);
               fail_count++;
            end
            if (rsp_payload.ram_isolated !== want.ram_isolated) begin
               $error("ram_isolated: expected %b, got %b", want.ram_isolated,
                      rsp_payload.ram_isolated);
               fail_count++;
            end
            if (!$isunknown(want.region))
               region_hits[want.region]++;
         end
      end
   end

   // Abandon a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule
